>>> hdl/software_timer_table_macros.svh
// Assertion macros used by the timer table top level.
`ifndef SOFTWARE_TIMER_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/sst_pkg.sv
// Types, codes and constants of the software timer table.
package sst_pkg;

	localparam int unsigned MAX_TIMERS_DEF = 16;
	localparam int unsigned MAX_RESULTS    = 16;

	localparam int unsigned APB_AW = 2;
	localparam int unsigned APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_TICK_STEP = 2'd0;
	localparam logic [7:0] TICK_STEP_RESET = 8'd1;

	localparam logic [2:0] OP_START        = 3'd0;
	localparam logic [2:0] OP_START_RELOAD = 3'd1;
	localparam logic [2:0] OP_STOP         = 3'd2;
	localparam logic [2:0] OP_QUERY        = 3'd3;
	localparam logic [2:0] OP_TICK         = 3'd4;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_FULL      = 2'd1;
	localparam logic [1:0] STS_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  requester;
		logic [15:0] event_bits;
		logic [15:0] duration;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] remaining;
		logic [4:0]  live_count;
		logic [31:0] clock_now;
		logic        fire_valid;
		logic [7:0]  fire_requester;
		logic [15:0] fire_bits;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  owner;
		logic [15:0] bits;
		logic [15:0] remaining;
		logic [15:0] period;
	} slot_t;

	typedef struct packed {
		logic [7:0]  requester;
		logic [15:0] bits;
	} fire_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fire_ctl_t;

endpackage

>>> hdl/software_timer_table.sv
// Top level of the software timer table: cell chain, sequencer, result register.
//
// Usage: commands enter on the cmd channel (cmd_valid / cmd_stall, payload cmd)
// and results leave on the rsp channel (rsp_valid / rsp_stall, payload rsp).
// A beat moves when valid is high and stall is low at a rising clock edge.
// Every command yields one or more result beats; the final one has last set.
// A tick that expires timers yields one beat per fired event (at most
// MAX_RESULTS), otherwise a single beat with fire_valid low.
// Timers live in a chain of MAX_TIMERS cells. Each command other than a spare
// opcode rotates the live entries once through the head of the chain, one entry
// per cycle, so that lookup, rewrite, count-down and removal keep insertion
// order. A closing step then inserts a new timer if one is due, and the result
// beats are loaded into the output register one after another.
// cmd_stall is high from acceptance until the last result beat has been loaded
// into the output register; the next command can be taken while that beat
// still waits on a stalled receiver. A stall on rsp holds the beat and pauses
// the draining of fired events; nothing is lost.
// tick_step is written via APB (address 0), by the user only while idle; no check in the block.
// Reset empties the table, clears the tick clock and sets tick_step to 1;
// cell contents are left as they are and are never read before written.
`include "software_timer_table_macros.svh"

module software_timer_table #(
	parameter int unsigned MAX_TIMERS = sst_pkg::MAX_TIMERS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// command channel
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  sst_pkg::cmd_t              cmd,
	// result channel
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output sst_pkg::rsp_t              rsp,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sst_pkg::APB_AW-1:0] paddr,
	input  logic [sst_pkg::APB_DW-1:0] pwdata,
	output logic [sst_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	localparam int unsigned CNT_W = $clog2(MAX_TIMERS + 1);
	localparam int unsigned IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int unsigned FIRE_DEPTH =
		(MAX_TIMERS < sst_pkg::MAX_RESULTS) ? MAX_TIMERS : sst_pkg::MAX_RESULTS;
	localparam int unsigned FCNT_W = $clog2(FIRE_DEPTH + 1);
	localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_TIMERS);
	localparam logic [FCNT_W-1:0] FIRE_LIMIT = FCNT_W'(FIRE_DEPTH);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PASS = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]       state_q;
	sst_pkg::cmd_t    cmd_q;
	logic [CNT_W-1:0] len_q;     // live entries (unvisited plus already rotated)
	logic [CNT_W-1:0] iter_q;    // entries still to visit in this pass
	logic             found_q;
	logic [15:0]      rem_q;
	logic [1:0]       status_q;
	logic [31:0]      clock_q;
	logic [7:0]       step_q;
	logic             out_valid_q;
	sst_pkg::rsp_t    rsp_q;

	sst_pkg::slot_t     slots [MAX_TIMERS];
	sst_pkg::slot_t     head;
	sst_pkg::slot_t     proc_slot;
	sst_pkg::slot_t     new_slot;
	sst_pkg::slot_t     wr_data;
	sst_pkg::fire_t     fire_head;
	sst_pkg::fire_ctl_t fire_ctl;
	sst_pkg::rsp_t      next_rsp;
	logic [FCNT_W-1:0]  fire_cnt;

	logic             cmd_acc;
	logic             pass_step;
	logic             pass_done;
	logic             hit;
	logic             keep;
	logic             fire;
	logic             is_start;
	logic             insert;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [CNT_W-1:0] len_dec;
	logic [15:0]      t_dec;
	logic             expired;
	logic             load_out;

	//------------------------------------------------------------------
	// Configuration port
	//------------------------------------------------------------------
	assign pready = 1'b1;
	assign prdata = (paddr == sst_pkg::ADDR_TICK_STEP) ?
		{{(sst_pkg::APB_DW - 8){1'b0}}, step_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= sst_pkg::TICK_STEP_RESET;
		end else if (psel && penable && pwrite && pready &&
		             paddr == sst_pkg::ADDR_TICK_STEP) begin
			step_q <= pwdata[7:0];
		end
	end

	//------------------------------------------------------------------
	// Head of the chain: decide what the visited entry becomes
	//------------------------------------------------------------------
	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign pass_step = (state_q == S_PASS) && (iter_q != '0);
	assign pass_done = (state_q == S_PASS) && (iter_q == '0);

	assign head = slots[0];
	assign hit  = !found_q && head.owner == cmd_q.requester &&
	              head.bits == cmd_q.event_bits;

	// count down by tick_step, saturating at zero
	assign t_dec   = (head.remaining <= {8'b0, step_q}) ? '0 :
	                 head.remaining - {8'b0, step_q};
	assign expired = (t_dec == '0);

	always_comb begin
		proc_slot = head;
		keep      = 1'b1;
		fire      = 1'b0;
		case (cmd_q.opcode) inside
			sst_pkg::OP_START, sst_pkg::OP_START_RELOAD: begin
				if (hit) begin
					proc_slot.remaining = cmd_q.duration;
					if (cmd_q.opcode == sst_pkg::OP_START_RELOAD) begin
						proc_slot.period = cmd_q.duration;
					end
				end
			end
			sst_pkg::OP_STOP: begin
				if (hit) begin
					proc_slot.bits = '0;
				end
			end
			sst_pkg::OP_TICK: begin
				// a live expired entry fires; periodic ones reload; expired one-shots and stopped entries leave
				fire = expired && (head.bits != '0);
				proc_slot.remaining = (fire && head.period != '0) ? head.period : t_dec;
				keep = (head.bits != '0) && (!expired || head.period != '0);
			end
			default: begin
			end
		endcase
	end

	assign is_start = (cmd_q.opcode == sst_pkg::OP_START) ||
	                  (cmd_q.opcode == sst_pkg::OP_START_RELOAD);
	assign insert   = pass_done && is_start && !found_q && (len_q != MAX_CNT);

	always_comb begin
		new_slot.owner     = cmd_q.requester;
		new_slot.bits      = cmd_q.event_bits;
		new_slot.remaining = cmd_q.duration;
		new_slot.period    = (cmd_q.opcode == sst_pkg::OP_START_RELOAD) ?
		                     cmd_q.duration : '0;
	end

	// a kept head goes back in behind the live entries; a new timer goes at the end
	assign len_dec = len_q - 1'b1;
	assign wr_en   = (pass_step && keep) || insert;
	assign wr_idx  = pass_step ? len_dec[IDX_W-1:0] : len_q[IDX_W-1:0];
	assign wr_data = pass_step ? proc_slot : new_slot;

	//------------------------------------------------------------------
	// Cell chain
	//------------------------------------------------------------------
	for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
		sst_pkg::cell_ctl_t cell_ctl;
		sst_pkg::slot_t     nbr;

		assign cell_ctl.shift = pass_step;
		assign cell_ctl.load  = wr_en && (wr_idx == IDX_W'(i));
		if (i == MAX_TIMERS - 1) begin : g_tail
			assign nbr = slots[i];
		end else begin : g_body
			assign nbr = slots[i+1];
		end

		sst_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.shift_in  (nbr),
			.load_data (wr_data),
			.slot      (slots[i])
		);
	end

	//------------------------------------------------------------------
	// Fired events
	//------------------------------------------------------------------
	assign load_out      = (state_q == S_EMIT) && (!out_valid_q || !rsp_stall);
	assign fire_ctl.push = pass_step && fire && (fire_cnt != FIRE_LIMIT);
	assign fire_ctl.pop  = load_out && (fire_cnt != '0);

	sst_fire_buf #(
		.DEPTH (FIRE_DEPTH)
	) u_fire_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (fire_ctl),
		.push_data ({head.owner, head.bits}),
		.head      (fire_head),
		.count     (fire_cnt)
	);

	//------------------------------------------------------------------
	// Sequencer
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			iter_q   <= '0;
			found_q  <= 1'b0;
			rem_q    <= '0;
			status_q <= sst_pkg::STS_OK;
			clock_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						state_q  <= S_PASS;
						found_q  <= 1'b0;
						rem_q    <= '0;
						status_q <= sst_pkg::STS_OK;
						// unused opcodes skip the walk
						iter_q   <= (cmd.opcode <= sst_pkg::OP_TICK) ? len_q : '0;
						if (cmd.opcode == sst_pkg::OP_TICK) begin
							clock_q <= clock_q + {24'b0, step_q};
						end
					end
				end
				S_PASS: begin
					if (pass_step) begin
						iter_q <= iter_q - 1'b1;
						if (!keep) begin
							len_q <= len_dec;
						end
						if (hit) begin
							found_q <= 1'b1;
							if (cmd_q.opcode == sst_pkg::OP_QUERY) begin
								rem_q <= head.remaining;
							end
						end
					end else begin
						state_q <= S_EMIT;
						if (insert) begin
							len_q <= len_q + 1'b1;
						end
						if (is_start && !found_q && len_q == MAX_CNT) begin
							status_q <= sst_pkg::STS_FULL;
						end else if (cmd_q.opcode == sst_pkg::OP_STOP && !found_q) begin
							status_q <= sst_pkg::STS_NOT_FOUND;
						end
					end
				end
				S_EMIT: begin
					if (load_out && next_rsp.last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd;
		end
	end

	//------------------------------------------------------------------
	// Result register
	//------------------------------------------------------------------
	always_comb begin
		next_rsp.status     = status_q;
		next_rsp.remaining  = rem_q;
		next_rsp.live_count = 5'(len_q);
		next_rsp.clock_now  = clock_q;
		if (fire_cnt != '0) begin
			next_rsp.fire_valid     = 1'b1;
			next_rsp.fire_requester = fire_head.requester;
			next_rsp.fire_bits      = fire_head.bits;
			next_rsp.last           = (fire_cnt == FCNT_W'(1));
		end else begin
			next_rsp.fire_valid     = 1'b0;
			next_rsp.fire_requester = '0;
			next_rsp.fire_bits      = '0;
			next_rsp.last           = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q <= next_rsp;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	`SST_ASSERT_NOW(a_len_bound, 1'b1, len_q <= MAX_CNT, "live count beyond table size")
	`SST_ASSERT_NOW(a_iter_bound, state_q == S_PASS, iter_q <= len_q,
		"walk longer than live entries")
	`SST_ASSERT_NOW(a_idle_drained, state_q == S_IDLE, fire_cnt == '0,
		"fired events left over when idle")
	`SST_ASSERT_NEXT(a_accept_walk, cmd_acc, state_q == S_PASS,
		"accepted command did not start a walk")
	`SST_ASSERT_NEXT(a_last_idle, load_out && next_rsp.last, state_q == S_IDLE,
		"sequencer busy after last beat")

endmodule

>>> hdl/sst_cell.sv
// One timer cell of the chain: shifts from its neighbor or loads a rewritten entry.
module sst_cell (
	input  logic              clk,
	input  sst_pkg::cell_ctl_t ctl,
	input  sst_pkg::slot_t    shift_in,
	input  sst_pkg::slot_t    load_data,
	output sst_pkg::slot_t    slot
);

	sst_pkg::slot_t slot_q;

	// load wins over shift: it places the rotated head behind the live entries
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			slot_q <= load_data;
		end else if (ctl.shift) begin
			slot_q <= shift_in;
		end
	end

	assign slot = slot_q;

endmodule

>>> hdl/sst_fire_buf.sv
// Shifting buffer of fired events, drained head first after a tick pass.
module sst_fire_buf #(
	parameter int unsigned DEPTH = sst_pkg::MAX_RESULTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sst_pkg::fire_ctl_t        ctl,
	input  sst_pkg::fire_t            push_data,
	output sst_pkg::fire_t            head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sst_pkg::fire_t   ent_q [DEPTH];
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.push) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (ctl.pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// push appends behind the held events; pop advances every entry by one
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ent_q[cnt_q[IDX_W-1:0]] <= push_data;
		end else if (ctl.pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

	assign head  = ent_q[0];
	assign count = cnt_q;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the software timer table: directed table, then random traffic.
module testbench;

	// Opcodes the block answers with an empty success beat and otherwise ignores.
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam int unsigned TABLE_DEPTH   = sst_pkg::MAX_TIMERS_DEF;
	localparam int unsigned TOTAL_OPS     = 460;
	localparam int unsigned PHASES        = 5;
	// Two full rotations of the chain plus a full burst of fired events, with margin.
	localparam int unsigned SETTLE_CYCLES = 2 * TABLE_DEPTH + sst_pkg::MAX_RESULTS + 8;
	localparam int unsigned HOLD_CYCLES   = 400;

	// One row of the opening table; typed rows carry status, remaining and live count.
	typedef struct {
		sst_pkg::cmd_t c;
		bit            typed;
		logic [1:0]    st;
		logic [15:0]   rem;
		logic [4:0]    live;
	} step_row_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cmd_valid = 1'b0;
	logic                         cmd_stall;
	sst_pkg::cmd_t                cmd       = '0;
	logic                         rsp_valid;
	logic                         rsp_stall = 1'b0;
	sst_pkg::rsp_t                rsp;
	logic                         psel      = 1'b0;
	logic                         penable   = 1'b0;
	logic                         pwrite    = 1'b0;
	logic [sst_pkg::APB_AW-1:0]   paddr     = '0;
	logic [sst_pkg::APB_DW-1:0]   pwdata    = '0;
	logic [sst_pkg::APB_DW-1:0]   prdata;
	logic                         pready;

	// Predicted timer table, tick clock and step size.
	sst_pkg::slot_t      timers [TABLE_DEPTH];
	int unsigned         live_timers = 0;
	logic [31:0]         tick_total  = '0;
	logic [7:0]          step_size   = sst_pkg::TICK_STEP_RESET;
	// Result beats still owed by the block, oldest first.
	sst_pkg::rsp_t       owed_results [$];

	int unsigned         mismatch_count = 0;
	int unsigned         ops_issued     = 0;
	int unsigned         burst_left     = 0;
	bit                  hold_req       = 1'b0;
	sst_pkg::rsp_t       want;

	// Walk through every special case of the table from a clean reset with
	// tick_step at its reset value of 1. Rows whose answer is plain are typed.
	step_row_t opening_rows [23] = '{
		'{'{sst_pkg::OP_QUERY, 8'h05, 16'h1234, 16'h0000},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd0},
		'{'{sst_pkg::OP_STOP, 8'h05, 16'h1234, 16'h0000},
			1'b1, sst_pkg::STS_NOT_FOUND, 16'd0, 5'd0},
		'{'{sst_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd0},
		'{'{sst_pkg::OP_START, 8'hFF, 16'hFFFF, 16'hFFFF},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd1},
		'{'{sst_pkg::OP_START_RELOAD, 8'h00, 16'h0001, 16'h0002},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd2},
		'{'{sst_pkg::OP_START, 8'h00, 16'h0000, 16'h0003},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd3},
		// restart keeps the slot and rewrites the count only
		'{'{sst_pkg::OP_START, 8'hFF, 16'hFFFF, 16'h0005},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd3},
		'{'{sst_pkg::OP_QUERY, 8'hFF, 16'hFFFF, 16'h0000},
			1'b1, sst_pkg::STS_OK, 16'd5, 5'd3},
		'{'{sst_pkg::OP_START_RELOAD, 8'h00, 16'h0001, 16'h0001},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd3},
		// periodic fires each tick; the zero-bit entry leaves silently on the first
		'{'{sst_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000},
			1'b0, sst_pkg::STS_OK, 16'd0, 5'd0},
		'{'{sst_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000},
			1'b0, sst_pkg::STS_OK, 16'd0, 5'd0},
		'{'{sst_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000},
			1'b0, sst_pkg::STS_OK, 16'd0, 5'd0},
		'{'{sst_pkg::OP_STOP, 8'hFF, 16'hFFFF, 16'h0000},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd2},
		// a stopped entry has zero bits, so a zero-bit key finds it again
		'{'{sst_pkg::OP_STOP, 8'hFF, 16'h0000, 16'h0000},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd2},
		'{'{sst_pkg::OP_QUERY, 8'hFF, 16'h0000, 16'h0000},
			1'b1, sst_pkg::STS_OK, 16'd2, 5'd2},
		'{'{sst_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000},
			1'b0, sst_pkg::STS_OK, 16'd0, 5'd0},
		// zero duration one-shot fires on the very next tick
		'{'{sst_pkg::OP_START, 8'h12, 16'h8000, 16'h0000},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd2},
		'{'{sst_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000},
			1'b0, sst_pkg::STS_OK, 16'd0, 5'd0},
		'{'{OP_SPARE_5, 8'hFF, 16'hFFFF, 16'hFFFF},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd1},
		'{'{OP_SPARE_7, 8'h00, 16'h0000, 16'h0000},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd1},
		'{'{OP_SPARE_6, 8'hA5, 16'h5A5A, 16'hA5A5},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd1},
		// stopping a periodic timer cancels its reload
		'{'{sst_pkg::OP_STOP, 8'h00, 16'h0001, 16'h0000},
			1'b1, sst_pkg::STS_OK, 16'd0, 5'd1},
		'{'{sst_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000},
			1'b0, sst_pkg::STS_OK, 16'd0, 5'd0}
	};

	software_timer_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #1 clk = ~clk;

	// Search the live part of the table for an (owner, bits) key.
	function automatic int find_timer(logic [7:0] who, logic [15:0] ev);
		for (int i = 0; i < live_timers; i++) begin
			if (timers[i].owner == who && timers[i].bits == ev)
				return i;
		end
		return -1;
	endfunction

	// Apply one command to the predicted table and queue the beats it owes.
	function automatic void timer_table_step(sst_pkg::cmd_t c);
		int             idx;
		int unsigned    w;
		int unsigned    n_fired;
		int unsigned    t;
		int unsigned    n;
		bit             fires;
		logic [1:0]     st;
		logic [15:0]    rem;
		sst_pkg::fire_t fired [sst_pkg::MAX_RESULTS];
		sst_pkg::rsp_t  beat;

		st      = sst_pkg::STS_OK;
		rem     = '0;
		n_fired = 0;
		case (c.opcode) inside
			sst_pkg::OP_START, sst_pkg::OP_START_RELOAD: begin
				idx = find_timer(c.requester, c.event_bits);
				if (idx < 0) begin
					if (live_timers < TABLE_DEPTH) begin
						idx = live_timers;
						timers[idx].owner  = c.requester;
						timers[idx].bits   = c.event_bits;
						timers[idx].period = '0;
						live_timers++;
					end else begin
						st = sst_pkg::STS_FULL;
					end
				end
				if (idx >= 0) begin
					timers[idx].remaining = c.duration;
					if (c.opcode == sst_pkg::OP_START_RELOAD)
						timers[idx].period = c.duration;
				end
			end
			sst_pkg::OP_STOP: begin
				idx = find_timer(c.requester, c.event_bits);
				if (idx >= 0)
					timers[idx].bits = '0;
				else
					st = sst_pkg::STS_NOT_FOUND;
			end
			sst_pkg::OP_QUERY: begin
				idx = find_timer(c.requester, c.event_bits);
				if (idx >= 0)
					rem = timers[idx].remaining;
			end
			sst_pkg::OP_TICK: begin
				tick_total = tick_total + step_size;
				w = 0;
				for (int r = 0; r < live_timers; r++) begin
					t     = timers[r].remaining;
					fires = 1'b0;
					t     = (t <= step_size) ? 0 : t - step_size;
					if (t == 0 && timers[r].period != 0 && timers[r].bits != 0) begin
						fires = 1'b1;
						t     = timers[r].period;
					end
					timers[r].remaining = 16'(t);
					if (t == 0 && timers[r].bits != 0)
						fires = 1'b1;
					if (fires && n_fired < sst_pkg::MAX_RESULTS) begin
						fired[n_fired].requester = timers[r].owner;
						fired[n_fired].bits      = timers[r].bits;
						n_fired++;
					end
					// close the gap left by expired or stopped entries
					if (t != 0 && timers[r].bits != 0) begin
						timers[w] = timers[r];
						w++;
					end
				end
				live_timers = w;
			end
			default: ;
		endcase

		n = (n_fired != 0) ? n_fired : 1;
		for (int k = 0; k < n; k++) begin
			beat.status         = st;
			beat.remaining      = rem;
			beat.live_count     = 5'(live_timers);
			beat.clock_now      = tick_total;
			beat.fire_valid     = (n_fired != 0);
			beat.fire_requester = (n_fired != 0) ? fired[k].requester : 8'h00;
			beat.fire_bits      = (n_fired != 0) ? fired[k].bits : 16'h0000;
			beat.last           = (k == n - 1);
			owed_results.push_back(beat);
		end
	endfunction

	// Offer one command beat, hold it until accepted, then pace the next one.
	// Called at a falling edge, returns at a falling edge.
	task automatic issue(sst_pkg::cmd_t c, bit typed = 1'b0,
			logic [1:0] st = sst_pkg::STS_OK,
			logic [15:0] rem = '0, logic [4:0] live = '0);
		sst_pkg::rsp_t beat;

		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		timer_table_step(c);
		// a typed row overrides the plain fields of its single predicted beat
		if (typed) begin
			beat            = owed_results.pop_back();
			beat.status     = st;
			beat.remaining  = rem;
			beat.live_count = live;
			owed_results.push_back(beat);
		end
		if (c.opcode <= sst_pkg::OP_TICK)
			ops_issued++;
		@(negedge clk);
		// bursts of back-to-back beats, now and then a long one, with gaps between
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 20);
		end else begin
			burst_left--;
		end
	endtask

	// Drop valid, wait until every owed beat has come, then let the block settle.
	task automatic settle();
		cmd_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Setup and access cycle on the register port; the write lands at the access edge.
	task automatic program_tick_step(logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= sst_pkg::ADDR_TICK_STEP;
		pwdata  <= {{(sst_pkg::APB_DW-8){1'b0}}, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		step_size = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// General traffic: keys mostly from the live table, else a small pool or anything.
	task automatic run_mixed(int unsigned count);
		sst_pkg::cmd_t c;
		int unsigned   pick;
		int unsigned   slot;

		repeat (count) begin
			pick = $urandom_range(0, 99);
			c.opcode = (pick < 22) ? sst_pkg::OP_START :
				(pick < 40) ? sst_pkg::OP_START_RELOAD :
				(pick < 52) ? sst_pkg::OP_STOP :
				(pick < 66) ? sst_pkg::OP_QUERY : sst_pkg::OP_TICK;
			if (live_timers != 0 && $urandom_range(0, 99) < 65) begin
				slot         = $urandom_range(0, live_timers - 1);
				c.requester  = timers[slot].owner;
				c.event_bits = timers[slot].bits;
			end else if ($urandom_range(0, 1)) begin
				c.requester  = 8'($urandom_range(0, 3));
				c.event_bits = 16'($urandom_range(0, 3));
			end else begin
				c.requester  = 8'($urandom);
				c.event_bits = 16'($urandom);
			end
			c.duration = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 6 * step_size));
			issue(c);
		end
	endtask

	// Fill the table with timers sharing one deadline, overflow it, tick them
	// all out at once, then stop what is left and sweep it with a final tick.
	task automatic run_fill();
		sst_pkg::cmd_t c;
		int unsigned   mult;
		int unsigned   guard;

		mult  = $urandom_range(1, 2);
		guard = 0;
		while (live_timers < TABLE_DEPTH && guard < 3 * TABLE_DEPTH) begin
			c.opcode     = $urandom_range(0, 1) ? sst_pkg::OP_START_RELOAD :
				sst_pkg::OP_START;
			c.requester  = 8'($urandom);
			c.event_bits = 16'($urandom_range(1, 65535));
			c.duration   = 16'(mult * step_size);
			issue(c);
			guard++;
		end
		repeat (2) begin
			c.opcode     = sst_pkg::OP_START;
			c.requester  = 8'($urandom);
			c.event_bits = 16'($urandom);
			c.duration   = 16'($urandom);
			issue(c);
		end
		repeat (mult + 1) begin
			c        = '0;
			c.opcode = sst_pkg::OP_TICK;
			issue(c);
		end
		for (int i = 0; i < live_timers; i++) begin
			if (timers[i].bits != 0) begin
				c.opcode     = sst_pkg::OP_STOP;
				c.requester  = timers[i].owner;
				c.event_bits = timers[i].bits;
				c.duration   = '0;
				issue(c);
			end
		end
		c        = '0;
		c.opcode = sst_pkg::OP_TICK;
		issue(c);
	endtask

	// Receiver: stall on a pattern of its own, in spans of differing density,
	// and once hold off for a long stretch so the block backs up into its input.
	initial begin
		int unsigned odds;
		int unsigned span;
		bit          held;

		held = 1'b0;
		@(posedge arst_n);
		forever begin
			odds = 25 * $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				if (hold_req && !held) begin
					rsp_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
					held = 1'b1;
					rsp_stall <= 1'b0;
				end else begin
					rsp_stall <= ($urandom_range(0, 99) < odds);
				end
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] expected, logic [31:0] actual);
		if (actual !== expected) begin
			$error("%s: expected %0h, actual %0h", name, expected, actual);
			mismatch_count++;
		end
	endfunction

	// Compare every accepted result beat against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_results.size() == 0) begin
				$error("result beat with nothing owed: %h", rsp);
				mismatch_count++;
			end else begin
				want = owed_results.pop_front();
				check_field("status",         want.status,         rsp.status);
				check_field("remaining",      want.remaining,      rsp.remaining);
				check_field("live_count",     want.live_count,     rsp.live_count);
				check_field("clock_now",      want.clock_now,      rsp.clock_now);
				check_field("fire_valid",     want.fire_valid,     rsp.fire_valid);
				check_field("fire_requester", want.fire_requester, rsp.fire_requester);
				check_field("fire_bits",      want.fire_bits,      rsp.fire_bits);
				check_field("last",           want.last,           rsp.last);
			end
		end
	end

	// Stimulus: reset, opening table, then random phases under several step sizes.
	initial begin
		logic [7:0]    step_plan [PHASES];
		int unsigned   pick;
		int unsigned   phase_end;
		int unsigned   mid;
		int unsigned   base;
		bit            paused;
		sst_pkg::cmd_t c;

		step_plan = '{8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd128,
			8'($urandom_range(2, 254))};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_rows[i])
			issue(opening_rows[i].c, opening_rows[i].typed, opening_rows[i].st,
				opening_rows[i].rem, opening_rows[i].live);

		base = ops_issued;
		for (int p = 0; p < PHASES; p++) begin
			// reprogram only with the block idle
			settle();
			program_tick_step(step_plan[p]);
			if (p == 1)
				hold_req = 1'b1;
			phase_end = base + (TOTAL_OPS - base) * (p + 1) / PHASES;
			mid       = (ops_issued + phase_end) / 2;
			paused    = 1'b0;
			while (ops_issued < phase_end) begin
				// once, halt the sender mid-phase until every owed beat is in
				if (p == 3 && !paused && ops_issued >= mid) begin
					settle();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					run_mixed($urandom_range(4, 16));
				end else if (pick < 75) begin
					run_fill();
				end else if (pick < 87) begin
					repeat ($urandom_range(2, 8)) begin
						c.opcode     = sst_pkg::OP_TICK;
						c.requester  = 8'($urandom);
						c.event_bits = 16'($urandom);
						c.duration   = 16'($urandom);
						issue(c);
					end
				end else begin
					// noise: any field value, spare opcodes included
					repeat ($urandom_range(1, 3)) begin
						c.opcode     = 3'($urandom);
						c.requester  = 8'($urandom);
						c.event_bits = 16'($urandom);
						c.duration   = 16'($urandom);
						issue(c);
					end
				end
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Bound the run far beyond the slowest correct one.
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
